// ===== design/vra_pkg.sv =====
// Package for the voxelwise RMS accumulator: widths, step counts,
// controller state type and the command/status words between controller and datapath.
// No dependencies.
package vra_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 39;
  localparam int SEEN_BITS   = 8;
  localparam int COUNT_BITS  = 9;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS   = (SUM_BITS + 1) / 2;
  localparam int RMS_BITS    = 16;
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int SQRT_STEPS  = ROOT_BITS;
  localparam int STEP_BITS   = 6;

  localparam logic [COUNT_BITS-1:0] MAX_IMAGES  = 9'd256;
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 9'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_SQ_INIT,
    ST_SQRT,
    ST_LOAD
  } vra_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic load_out;
  } vra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } vra_status_t;

endpackage

// ===== design/voxelwise_rms_accumulator_unit.sv =====
// Voxelwise RMS accumulator: rms = floor(sqrt(floor(sum of squares / image_count))).
// A sample that does not close a voxel passes through capture, square and add.
// The closing sample, with the output free, goes on through 39 divider steps, a root setup,
// 20 root steps and the output load.
// The result register lets the next voxel start while a word waits on the output.
// Synchronous active-high reset clears sum, counter and output valid; image_count resets to 1.
module voxelwise_rms_accumulator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vra_pkg::COUNT_BITS-1:0]  image_count,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vra_pkg::SAMPLE_BITS-1:0] sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vra_pkg::RMS_BITS-1:0]    rms
);
  import vra_pkg::*;

  vra_cmd_t    cmd;
  vra_status_t status;

  // Configuration is taken only while the block is idle and no sample is offered.
  assign cfg_ready = !in_stall && !in_valid;

  // Controller.
  vra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  vra_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .image_count (image_count),
    .sample      (sample),
    .cmd         (cmd),
    .status      (status),
    .rms         (rms)
  );

`ifndef NO_ASSERTIONS
  // An accepted sample occupies the block for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted sample");

  // A new output word only appears after a busy cycle.
  a_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word loaded while idle");

  // Taking a new sample never drops a waiting output word.
  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && out_valid && out_stall) |=> out_valid)
    else $error("waiting output word lost on sample accept");
`endif

endmodule

// ===== design/vra_ctrl.sv =====
// Controller state machine of the voxelwise RMS accumulator.
// Sequences square, accumulate, divide and root steps. Depends on vra_pkg.
module vra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  vra_pkg::vra_status_t status,
  output vra_pkg::vra_cmd_t    cmd
);
  import vra_pkg::*;

  vra_state_t           state;
  vra_state_t           state_next;
  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;
  logic                 out_free;
  logic                 div_end;
  logic                 sqrt_end;

  assign out_free = !out_valid || !out_stall;
  assign div_end  = (step == STEP_BITS'(DIV_STEPS - 1));
  assign sqrt_end = (step == STEP_BITS'(SQRT_STEPS - 1));

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and step count.
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        step_next = '0;
        if (status.last) state_next = ST_DIV;
        else state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (div_end) begin
          state_next = ST_SQ_INIT;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SQ_INIT: begin
        state_next = ST_SQRT;
        step_next  = '0;
      end
      ST_SQRT: begin
        if (sqrt_end) begin
          state_next = ST_LOAD;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_LOAD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // Command outputs decoded from the state.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_MUL:     cmd.mul       = 1'b1;
      ST_ACC:     cmd.acc       = 1'b1;
      ST_DIV:     cmd.div_step  = 1'b1;
      ST_SQ_INIT: cmd.sqrt_init = 1'b1;
      ST_SQRT:    cmd.sqrt_step = 1'b1;
      ST_LOAD:    cmd.load_out  = out_free;
      default:    cmd           = '0;
    endcase
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/vra_dp.sv =====
// Datapath of the voxelwise RMS accumulator: magnitude, square, sum,
// restoring divider, digit-by-digit square root and output register. Depends on vra_pkg.
module vra_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [vra_pkg::COUNT_BITS-1:0]       image_count,
  input  logic [vra_pkg::SAMPLE_BITS-1:0]      sample,
  input  vra_pkg::vra_cmd_t                    cmd,
  output vra_pkg::vra_status_t                 status,
  output logic [vra_pkg::RMS_BITS-1:0]         rms
);
  import vra_pkg::*;

  logic [COUNT_BITS-1:0]  count_reg;
  logic [COUNT_BITS-1:0]  count_eff;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PROD_BITS-1:0]   prod;
  logic [SUM_BITS-1:0]    square_sum;
  logic [SUM_BITS-1:0]    sum_next;
  logic [SEEN_BITS-1:0]   samples_seen;
  logic [COUNT_BITS-1:0]  seen_plus;
  logic [SUM_BITS-1:0]    dq;
  logic [COUNT_BITS-1:0]  div_rem;
  logic [COUNT_BITS:0]    div_trial;
  logic                   div_bit;
  logic [2*ROOT_BITS-1:0] sq_x;
  logic [ROOT_BITS:0]     sq_rem;
  logic [ROOT_BITS:0]     sq_rem_next;
  logic [ROOT_BITS-1:0]   root;
  logic [ROOT_BITS+2:0]   sq_shift;
  logic [ROOT_BITS+2:0]   sq_trial;
  logic                   sq_bit;

  // Image count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= COUNT_RESET;
    end else if (cfg_write) begin
      count_reg <= image_count;
    end
  end

  // Zero acts as one, and counts above the limit are clamped.
  always_comb begin
    count_eff = count_reg;
    if (count_reg == '0) count_eff = COUNT_BITS'(1);
    if (count_reg > MAX_IMAGES) count_eff = MAX_IMAGES;
  end

  // This sample closes the voxel once the count is reached or passed.
  assign seen_plus   = {1'b0, samples_seen} + COUNT_BITS'(1);
  assign status.last = (seen_plus >= count_eff);
  assign sum_next    = square_sum + SUM_BITS'(prod);

  // Magnitude capture and squaring.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag <= sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    end
    if (cmd.mul) begin
      prod <= mag * mag;
    end
  end

  // Running sum and sample counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      samples_seen <= '0;
    end else if (cmd.acc) begin
      if (status.last) begin
        square_sum   <= '0;
        samples_seen <= '0;
      end else begin
        square_sum   <= sum_next;
        samples_seen <= seen_plus[SEEN_BITS-1:0];
      end
    end
  end

  // One quotient bit per step of the restoring divider.
  assign div_trial = {div_rem, dq[SUM_BITS-1]};
  assign div_bit   = (div_trial >= {1'b0, count_eff});

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      dq      <= sum_next;
      div_rem <= '0;
    end else if (cmd.div_step) begin
      dq <= {dq[SUM_BITS-2:0], div_bit};
      if (div_bit) div_rem <= COUNT_BITS'(div_trial - {1'b0, count_eff});
      else div_rem <= div_trial[COUNT_BITS-1:0];
    end
  end

  // One root bit per step, taking two radicand bits at a time.
  assign sq_shift = {sq_rem, sq_x[2*ROOT_BITS-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_bit   = (sq_shift >= sq_trial);
  always_comb begin
    if (sq_bit) sq_rem_next = (ROOT_BITS+1)'(sq_shift - sq_trial);
    else sq_rem_next = sq_shift[ROOT_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_x   <= (2*ROOT_BITS)'(dq);
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_x   <= {sq_x[2*ROOT_BITS-3:0], 2'b00};
      sq_rem <= sq_rem_next;
      root   <= {root[ROOT_BITS-2:0], sq_bit};
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rms <= root[RMS_BITS-1:0];
    end
  end

endmodule

// ===== bench/voxelwise_rms_accumulator_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench for voxelwise_rms_accumulator_unit: drives voxel samples and image counts,
// predicts every rms word and checks each one. Depends on vra_pkg and the unit.
module voxelwise_rms_accumulator_unit_test;
  import vra_pkg::*;

  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 500;
  localparam longint unsigned SUM_MASK = (64'd1 << SUM_BITS) - 1;

  // Predicts the rms word of each voxel and holds the words still to come.
  class voxel_rms_predictor;
    int unsigned count_reg;
    longint unsigned square_sum;
    int unsigned samples_seen;
    logic [RMS_BITS-1:0] expected_rms[$];
    int unsigned errors;

    function new();
      count_reg = COUNT_RESET;
      square_sum = 0;
      samples_seen = 0;
      errors = 0;
    endfunction

    function void write_count(logic [COUNT_BITS-1:0] value);
      count_reg = value;
    endfunction

    // A zero count acts as one; counts above the maximum are clamped.
    function int unsigned samples_per_voxel();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_IMAGES) return MAX_IMAGES;
      return count_reg;
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= x) r = trial;
      end
      return r;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s);
      int unsigned n;
      int v;
      longint unsigned mag;
      logic [RMS_BITS-1:0] word;
      n = samples_per_voxel();
      v = $signed(s);
      mag = (v < 0) ? longint'(-v) : longint'(v);
      square_sum = (square_sum + mag * mag) & SUM_MASK;
      // The sample that reaches the count closes the voxel, even after a lowered count.
      if (samples_seen + 1 >= n) begin
        word = RMS_BITS'(floor_root(square_sum / n));
        expected_rms = {expected_rms, word};
        square_sum = 0;
        samples_seen = 0;
      end else begin
        samples_seen = (samples_seen + 1) & 8'hFF;
      end
    endfunction

    function void check_rms(logic [RMS_BITS-1:0] actual);
      logic [RMS_BITS-1:0] want;
      if (expected_rms.size() == 0) begin
        $error("rms: no word expected, actual %0d", actual);
        errors++;
        return;
      end
      want = expected_rms.pop_front();
      if (actual !== want) begin
        $error("rms mismatch: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rms.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_BITS-1:0] image_count = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RMS_BITS-1:0] rms;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  voxel_rms_predictor predictor;

  voxelwise_rms_accumulator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .image_count (image_count),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rms         (rms)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor of all three channels, plus the watchdog on accepted words.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) predictor.write_count(image_count);
      if (in_valid && !in_stall) predictor.note_sample(sample);
      if (out_valid && !out_stall) predictor.check_rms(rms);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one sample word, with random gaps, and returns once it is taken.
  // Valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every expected rms word has come out.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  // A sample that closes no voxel may still be in flight, so allow extra cycles.
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_BITS-1:0] value);
    cfg_valid <= 1'b1;
    image_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SAMPLE_BITS'($urandom_range(16) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Mostly small counts; full-size and out-of-range counts now and then.
  function automatic logic [COUNT_BITS-1:0] pick_count(int ph, int blk);
    if (ph == 1 && blk == 0) return 9'h1FF;
    if (ph == 2 && blk == 0) return MAX_IMAGES;
    case ($urandom_range(15))
      0: return COUNT_BITS'($urandom_range(256, 511));
      1: return '0;
      2: return 9'd1;
      default: return COUNT_BITS'($urandom_range(2, 20));
    endcase
  endfunction

  initial begin
    int n;
    int voxels;
    int sent;
    int blk;
    int k;
    logic [COUNT_BITS-1:0] cnt;
    predictor = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset count of one: each sample is its own voxel, field extremes first.
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    settle();

    // A zero count behaves as one.
    write_count('0);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    settle();

    // Largest possible mean.
    write_count(9'd3);
    repeat (3) send_sample(16'h8000);
    settle();

    // Count lowered to the number of samples already taken: the next sample closes the voxel.
    write_count(9'd5);
    send_sample(16'h00FF);
    send_sample(16'hFF00);
    settle();
    write_count(9'd2);
    send_sample(16'h7FFF);
    settle();

    // Count raised mid-voxel: the partial sum carries over.
    write_count(9'd3);
    send_sample(16'h0123);
    settle();
    write_count(9'd4);
    repeat (3) send_sample(random_sample());
    settle();

    // Random phases, each with its own idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      sent = 0;
      blk = 0;
      while (sent < ITEMS_PER_PHASE) begin
        settle();
        cnt = pick_count(ph, blk);
        write_count(cnt);
        // Samples per voxel for the count just written; zero acts as one.
        if (cnt == '0) n = 1;
        else if (cnt > MAX_IMAGES) n = int'(MAX_IMAGES);
        else n = int'(cnt);
        voxels = (n > 32) ? 1 : $urandom_range(2, 12);
        repeat (voxels * n) send_sample(random_sample());
        sent += voxels * n;
        // Sometimes leave a voxel unfinished so the next count lands mid-voxel.
        if (n > 1 && $urandom_range(3) == 0) begin
          k = $urandom_range(1, n - 1);
          repeat (k) send_sample(random_sample());
          sent += k;
        end
        if ($urandom_range(4) == 0) begin
          wait_results();
          @(posedge clk);
        end
        blk++;
      end
    end

    settle();
    if (predictor.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
